// ----- hdl/c2d_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// c2d_pkg
// Shared types and codes for the 3x3 valid convolution block.
// ---------------------------------------------------------------------------
package c2d_pkg;

    // Kernel taps of a 3x3 window
    localparam int TAPS = 9;

    // Request kinds carried by the mode field
    localparam logic MODE_COEF  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    typedef logic signed [15:0] coef_t;
    typedef logic signed [31:0] prod_t;
    typedef logic signed [33:0] part_t;
    typedef logic signed [34:0] sum_t;

    // Nine samples or coefficients, tap index = row * 3 + column
    typedef coef_t [TAPS-1:0] coef_vec_t;

    // Position and end-of-frame mark of one output pixel
    typedef struct packed {
        logic [3:0] row;
        logic [3:0] col;
        logic       last;
    } tag_t;

endpackage : c2d_pkg
`default_nettype wire

// ----- hdl/c2d_dot9.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// c2d_dot9
// Three-stage dot product of nine Q8.8 taps with nine Q8.8 coefficients:
// products, three partial sums, final sum in the output register.
// ---------------------------------------------------------------------------
module c2d_dot9 (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire c2d_pkg::tag_t      in_tag,
    input  wire c2d_pkg::coef_vec_t kernel,
    input  wire c2d_pkg::coef_vec_t taps,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output c2d_pkg::sum_t           out_sum,
    output c2d_pkg::tag_t           out_tag
);

    c2d_pkg::prod_t prod_reg [c2d_pkg::TAPS];
    c2d_pkg::part_t part_reg [3];
    c2d_pkg::tag_t  prod_tag_reg;
    c2d_pkg::tag_t  part_tag_reg;
    logic           prod_valid_reg;
    logic           part_valid_reg;
    logic           out_valid_reg;
    c2d_pkg::sum_t  sum_reg;
    c2d_pkg::tag_t  out_tag_reg;

    logic out_go;
    logic part_go;
    logic prod_go;

    // Stage moves when empty or when its contents move on
    assign out_go   = !out_valid_reg || out_ready;
    assign part_go  = !part_valid_reg || out_go;
    assign prod_go  = !prod_valid_reg || part_go;
    assign in_ready = prod_go;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            part_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_go)
                prod_valid_reg <= in_valid;
            if (part_go)
                part_valid_reg <= prod_valid_reg;
            if (out_go)
                out_valid_reg <= part_valid_reg;
        end
    end

    // Multiply each tap by its coefficient
    always_ff @(posedge clk)
    begin
        if (prod_go)
        begin
            for (int t = 0; t < c2d_pkg::TAPS; t++)
                prod_reg[t] <= $signed(kernel[t]) * $signed(taps[t]);
            prod_tag_reg <= in_tag;
        end
    end

    // Sum one kernel row per partial
    always_ff @(posedge clk)
    begin
        if (part_go)
        begin
            for (int i = 0; i < 3; i++)
                part_reg[i] <= 34'(prod_reg[3*i]) + 34'(prod_reg[3*i+1])
                             + 34'(prod_reg[3*i+2]);
            part_tag_reg <= prod_tag_reg;
        end
    end

    // Final sum into the output register
    always_ff @(posedge clk)
    begin
        if (out_go)
        begin
            sum_reg     <= 35'(part_reg[0]) + 35'(part_reg[1]) + 35'(part_reg[2]);
            out_tag_reg <= part_tag_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = sum_reg;
    assign out_tag   = out_tag_reg;

endmodule : c2d_dot9
`default_nettype wire

// ----- hdl/conv2d_3x3_valid_top.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// conv2d_3x3_valid_top
// Streaming 3x3 valid cross-correlation over an IMAGE_SIZE square frame.
// ---------------------------------------------------------------------------
// Throughput: one request (pixel or coefficient) per cycle while out_ready
//   stays high; the line store is read at acceptance and written as the pixel leaves stage 1.
// Path: a pixel that completes a window passes the line store read in stage 1,
//   then the products, partial sums and output register of c2d_dot9.
// Reset: clears pixel/coefficient counters and all pipeline valid flags;
//   kernel, line store and window hold no defined value until written.
module conv2d_3x3_valid_top #(
    parameter int IMAGE_SIZE = 15
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          mode,
    input  wire logic [15:0]   value,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [34:0]        sum,
    output logic [3:0]         out_row,
    output logic [3:0]         out_col,
    output logic               last
);

    localparam int CW = (IMAGE_SIZE > 1) ? $clog2(IMAGE_SIZE) : 1;
    localparam int RW = (CW > 4) ? CW : 4;

    // Two previous rows per column: upper half row r-2, lower half row r-1
    logic [31:0] line_mem [IMAGE_SIZE];
    logic [31:0] line_rd_reg;

    c2d_pkg::coef_t kernel_reg [c2d_pkg::TAPS];
    c2d_pkg::coef_t win_reg [3][2];
    logic [3:0]     coeff_idx_reg;
    logic [CW-1:0]  row_reg;
    logic [CW-1:0]  col_reg;

    logic           s1_valid_reg;
    logic           s1_emit_reg;
    logic [CW-1:0]  s1_col_reg;
    c2d_pkg::coef_t s1_pix_reg;
    c2d_pkg::tag_t  s1_tag_reg;

    logic               accept;
    logic               pix_accept;
    logic               coef_accept;
    logic               s1_leave;
    logic               dot_ready;
    logic               dot_valid;
    logic               emit_next;
    logic [RW-1:0]      row_off;
    logic [RW-1:0]      col_off;
    c2d_pkg::tag_t      tag_next;
    c2d_pkg::coef_t     column [3];
    c2d_pkg::coef_vec_t kernel_vec;
    c2d_pkg::coef_vec_t tap_vec;
    c2d_pkg::sum_t      dot_sum;
    c2d_pkg::tag_t      dot_tag;

    // Handshake: stage 1 frees when it drops a non-emitting pixel or the
    // dot product takes it
    assign dot_valid   = s1_valid_reg && s1_emit_reg;
    assign s1_leave    = s1_valid_reg && (!s1_emit_reg || dot_ready);
    assign in_ready    = !s1_valid_reg || s1_leave;
    assign accept      = in_valid && in_ready;
    assign pix_accept  = accept && (mode == c2d_pkg::MODE_PIXEL);
    assign coef_accept = accept && (mode == c2d_pkg::MODE_COEF);

    // Window position of the incoming pixel
    assign row_off   = RW'(row_reg) - RW'(2);
    assign col_off   = RW'(col_reg) - RW'(2);
    assign emit_next = (row_reg >= CW'(2)) && (col_reg >= CW'(2));
    always_comb
    begin
        tag_next.row  = row_off[3:0];
        tag_next.col  = col_off[3:0];
        tag_next.last = (row_reg == CW'(IMAGE_SIZE - 1))
                     && (col_reg == CW'(IMAGE_SIZE - 1));
    end

    // Coefficient index and raster counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_idx_reg <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (coef_accept)
                coeff_idx_reg <= (coeff_idx_reg == 4'(c2d_pkg::TAPS - 1))
                               ? 4'd0 : coeff_idx_reg + 4'd1;
            if (pix_accept)
            begin
                if (col_reg == CW'(IMAGE_SIZE - 1))
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == CW'(IMAGE_SIZE - 1))
                             ? '0 : row_reg + CW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (in_ready)
                s1_valid_reg <= pix_accept;
        end
    end

    // Load kernel coefficients
    always_ff @(posedge clk)
    begin
        if (coef_accept)
            kernel_reg[coeff_idx_reg] <= c2d_pkg::coef_t'(value);
    end

    // Stage 1 payload and line store read
    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            line_rd_reg <= line_mem[col_reg];
            s1_pix_reg  <= c2d_pkg::coef_t'(value);
            s1_col_reg  <= col_reg;
            s1_emit_reg <= emit_next;
            s1_tag_reg  <= tag_next;
        end
    end

    // Column c of rows r-2, r-1 and r
    assign column[0] = line_rd_reg[31:16];
    assign column[1] = line_rd_reg[15:0];
    assign column[2] = s1_pix_reg;

    // Shift rows up in the line store and advance the window
    always_ff @(posedge clk)
    begin
        if (s1_leave)
        begin
            line_mem[s1_col_reg] <= {line_rd_reg[15:0], s1_pix_reg};
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= column[i];
            end
        end
    end

    // Gather taps and coefficients
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tap_vec[3*i]   = win_reg[i][0];
            tap_vec[3*i+1] = win_reg[i][1];
            tap_vec[3*i+2] = column[i];
        end
        for (int t = 0; t < c2d_pkg::TAPS; t++)
            kernel_vec[t] = kernel_reg[t];
    end

    c2d_dot9 u_dot9 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dot_valid),
        .in_ready  (dot_ready),
        .in_tag    (s1_tag_reg),
        .kernel    (kernel_vec),
        .taps      (tap_vec),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_sum   (dot_sum),
        .out_tag   (dot_tag)
    );

    assign sum     = dot_sum;
    assign out_row = dot_tag.row;
    assign out_col = dot_tag.col;
    assign last    = dot_tag.last;

`ifndef NO_ASSERTIONS
    // Coefficient index wraps at the last tap
    assert property (@(posedge clk) disable iff (!rst_n)
        coeff_idx_reg < 4'(c2d_pkg::TAPS))
        else $error("coefficient index out of range");

    // Raster counters stay inside the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= CW'(IMAGE_SIZE - 1)) && (col_reg <= CW'(IMAGE_SIZE - 1)))
        else $error("pixel counter out of range");

    // Input stalls only behind a held stage 1 pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s1_emit_reg && !dot_ready))
        else $error("input stalled without a held pixel");

    // Frame end lands on the bottom-right output
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (out_row == out_col))
        else $error("last flag off the diagonal corner");
`endif

endmodule : conv2d_3x3_valid_top
`default_nettype wire
